>>> design/mcrt_pkg.sv
// shared types, constants and codes for the mesh cell ray traversal core
package mcrt_pkg;

  // parameter defaults and fixed widths
  localparam int INDEX_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int DIV_NUM_W      = 33;
  localparam int DIV_DEN_W      = 31;
  localparam int DIV_CNT_W      = 6;

  localparam logic [30:0] DIST_MAX = 31'h7fffffff;

  // operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_TOL = 3'd6;

  // crossed face codes
  localparam logic [2:0] FACE_NONE = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Z = 3'd6;

  // per-axis on-face flag
  typedef enum logic [1:0] {
    FLAG_NONE = 2'd0,
    FLAG_LOW  = 2'd1,
    FLAG_HIGH = 2'd2
  } flag_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOC,
    S_LDIV,
    S_LFIN,
    S_MUL,
    S_OFF,
    S_FACE,
    S_FDIV,
    S_CMP,
    S_NEXT,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] cell_x;
    logic signed [11:0] cell_y;
    logic signed [11:0] cell_z;
    logic [30:0]        face_distance;
    logic [2:0]         crossed_face;
  } out_item_t;

  // queue entry: classified transaction
  typedef struct packed {
    logic     advance;
    in_item_t item;
  } queue_entry_t;

  // configuration as seen by the back end, pitches already made nonzero
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [30:0]        pitch_x;
    logic [30:0]        pitch_y;
    logic [30:0]        pitch_z;
    logic [15:0]        face_tol;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] rem_init;
    logic [DIV_CNT_W-1:0] count;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> design/mcrt_front.sv
// front end: accepts transactions, classifies them and queues them for the back end
module mcrt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcrt_pkg::in_item_t   in_data,
  output logic                 q_valid,
  output mcrt_pkg::queue_entry_t q_entry,
  input  logic                 q_pop
);

  localparam int PW = $clog2(mcrt_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mcrt_pkg::QUEUE_DEPTH + 1);

  mcrt_pkg::queue_entry_t mem_r [mcrt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign in_stall = (cnt_r == CW'(mcrt_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != '0);
  assign q_entry  = mem_r[rd_ptr_r];

  // storage, tagged with the operation class
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].advance <= (in_data.operation == mcrt_pkg::OP_ADVANCE);
      mem_r[wr_ptr_r].item    <= in_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= PW'((32'(wr_ptr_r) + 1) % mcrt_pkg::QUEUE_DEPTH);
      if (pop)  rd_ptr_r <= PW'((32'(rd_ptr_r) + 1) % mcrt_pkg::QUEUE_DEPTH);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

>>> design/mcrt_div.sv
// restoring divider, one quotient bit per cycle, shared by all divisions
module mcrt_div (
  input  logic                clk,
  input  logic                rst_n,
  input  mcrt_pkg::div_req_t  req,
  output mcrt_pkg::div_rsp_t  rsp
);

  localparam int NW = mcrt_pkg::DIV_NUM_W;
  localparam int DW = mcrt_pkg::DIV_DEN_W;

  logic [DW-1:0]                 r_r, div_r;
  logic [NW-1:0]                 n_r, q_r;
  logic [mcrt_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          done_r;
  logic [DW:0]                   sh;
  logic                          ge;

  // one shift and trial subtract
  assign sh = {r_r, n_r[NW-1]};
  assign ge = (sh >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (req.start) begin
      r_r   <= req.rem_init;
      n_r   <= req.num;
      q_r   <= '0;
      div_r <= req.divisor;
    end else if (cnt_r != '0) begin
      r_r <= ge ? DW'(sh - {1'b0, div_r}) : DW'(sh);
      n_r <= {n_r[NW-2:0], 1'b0};
      q_r <= {q_r[NW-2:0], ge};
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= req.count;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == mcrt_pkg::DIV_CNT_W'(1));
      if (cnt_r != '0) cnt_r <= cnt_r - mcrt_pkg::DIV_CNT_W'(1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

endmodule

>>> design/mcrt_back.sv
// back end: per-axis sequencer for cell location and face stepping
module mcrt_back #(
  parameter int INDEX_BITS = mcrt_pkg::INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mcrt_pkg::cfg_t         cfg,
  input  logic                   q_valid,
  input  mcrt_pkg::queue_entry_t q_entry,
  output logic                   q_pop,
  output mcrt_pkg::div_req_t     div_req,
  input  mcrt_pkg::div_rsp_t     div_rsp,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mcrt_pkg::out_item_t    out_data
);

  localparam int QW = 36;
  localparam int PW = INDEX_BITS + 32;
  localparam int OW = INDEX_BITS + 35;
  localparam int IW = INDEX_BITS + 1;
  localparam logic signed [QW-1:0] Q_MAX = (QW'(1) <<< (INDEX_BITS - 1)) - QW'(1);
  localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);
  localparam logic signed [IW-1:0] I_MAX = (IW'(1) <<< (INDEX_BITS - 1)) - IW'(1);
  localparam logic signed [IW-1:0] I_MIN = -I_MAX - IW'(1);

  mcrt_pkg::back_state_t state_r, state_nxt;
  logic [1:0]                   axis_r, axis_nxt;
  logic                         side_r, side_nxt;
  mcrt_pkg::queue_entry_t       ent_r;
  logic signed [INDEX_BITS-1:0] idx_r [3];
  logic signed [INDEX_BITS-1:0] idx_nxt [3];
  mcrt_pkg::flag_t              flag_r [3];
  mcrt_pkg::flag_t              flag_nxt [3];
  logic signed [PW-1:0]         prod_r;
  logic signed [OW-1:0]         lo_r;
  logic [30:0]                  d_r, d_nxt;
  logic [30:0]                  dist_r, dist_nxt;
  logic [2:0]                   face_r, face_nxt;
  logic                         found_r, found_nxt;
  logic                         out_valid_r;
  mcrt_pkg::out_item_t          out_data_r, out_data_nxt;
  logic                         load_out;

  // per-axis operand select
  logic signed [31:0]           pos_a, org_a;
  logic signed [15:0]           dir_a;
  logic [30:0]                  pit_a;
  logic [15:0]                  tol;
  logic signed [INDEX_BITS-1:0] idx_a;
  mcrt_pkg::flag_t              flag_a;

  always_comb begin
    case (axis_r)
      2'd1: begin
        pos_a = ent_r.item.pos_y; dir_a = ent_r.item.dir_y;
        org_a = cfg.origin_y;     pit_a = cfg.pitch_y;
      end
      2'd2: begin
        pos_a = ent_r.item.pos_z; dir_a = ent_r.item.dir_z;
        org_a = cfg.origin_z;     pit_a = cfg.pitch_z;
      end
      default: begin
        pos_a = ent_r.item.pos_x; dir_a = ent_r.item.dir_x;
        org_a = cfg.origin_x;     pit_a = cfg.pitch_x;
      end
    endcase
    idx_a  = (axis_r == 2'd1) ? idx_r[1] : (axis_r == 2'd2) ? idx_r[2] : idx_r[0];
    flag_a = (axis_r == 2'd1) ? flag_r[1] : (axis_r == 2'd2) ? flag_r[2] : flag_r[0];
    tol    = cfg.face_tol;
  end

  // locate: relative position and its magnitude
  logic signed [32:0] rel;
  logic               rel_neg;
  logic [32:0]        rel_mag;
  assign rel     = 33'(pos_a) - 33'(org_a);
  assign rel_neg = rel[32];
  assign rel_mag = rel_neg ? 33'(-rel) : 33'(rel);

  // locate: floor quotient, remainder and face snapping
  logic signed [QW-1:0] qf, qs, qsat;
  logic [30:0]          remf;
  mcrt_pkg::flag_t      lflag;
  always_comb begin
    if (!rel_neg) begin
      qf   = QW'(signed'({1'b0, div_rsp.quot}));
      remf = div_rsp.rem;
    end else if (div_rsp.rem == '0) begin
      qf   = -QW'(signed'({1'b0, div_rsp.quot}));
      remf = '0;
    end else begin
      qf   = -QW'(signed'({1'b0, div_rsp.quot})) - QW'(1);
      remf = pit_a - div_rsp.rem;
    end
    qs    = qf;
    lflag = mcrt_pkg::FLAG_NONE;
    if (remf < 31'(tol)) begin
      if (dir_a < 0) begin
        qs = qf - QW'(1); lflag = mcrt_pkg::FLAG_HIGH;
      end else begin
        lflag = mcrt_pkg::FLAG_LOW;
      end
    end else if ((pit_a - remf) < 31'(tol)) begin
      if (dir_a < 0) begin
        lflag = mcrt_pkg::FLAG_HIGH;
      end else begin
        qs = qf + QW'(1); lflag = mcrt_pkg::FLAG_LOW;
      end
    end
    if (qs > Q_MAX)      qsat = Q_MAX;
    else if (qs < Q_MIN) qsat = Q_MIN;
    else                 qsat = qs;
  end

  // advance: face offset, hit test and early saturation
  logic signed [OW-1:0] off;
  logic [OW-1:0]        off_mag;
  logic [15:0]          um;
  logic                 skip, can_hit, big;
  always_comb begin
    off     = side_r ? lo_r + OW'(signed'({1'b0, pit_a})) : lo_r;
    off_mag = off[OW-1] ? OW'(-off) : OW'(off);
    um      = dir_a[15] ? 16'(-dir_a) : 16'(dir_a);
    skip    = (!side_r && flag_a == mcrt_pkg::FLAG_LOW) ||
              (side_r && flag_a == mcrt_pkg::FLAG_HIGH);
    can_hit = !skip && (dir_a != '0) && (off != '0) && (off[OW-1] == dir_a[15]);
    big     = (off_mag >= (OW'(um) << 16));
  end

  // advance: index step and flags after the nearest face
  logic [1:0]          fa;
  logic signed [IW-1:0] istep;
  always_comb begin
    fa    = 2'((face_r - 3'd1) >> 1);
    istep = '0;
    for (int a = 0; a < 3; a++) begin
      idx_nxt[a]  = idx_r[a];
      flag_nxt[a] = flag_r[a];
    end
    if (ent_r.advance) begin
      for (int a = 0; a < 3; a++) flag_nxt[a] = mcrt_pkg::FLAG_NONE;
      if (found_r) begin
        for (int a = 0; a < 3; a++) begin
          if (2'(a) == fa) begin
            istep = face_r[0] ? IW'(idx_r[a]) - IW'(1) : IW'(idx_r[a]) + IW'(1);
            if (istep > I_MAX)      idx_nxt[a] = INDEX_BITS'(I_MAX);
            else if (istep < I_MIN) idx_nxt[a] = INDEX_BITS'(I_MIN);
            else                    idx_nxt[a] = INDEX_BITS'(istep);
            flag_nxt[a] = face_r[0] ? mcrt_pkg::FLAG_HIGH : mcrt_pkg::FLAG_LOW;
          end
        end
      end
    end
    out_data_nxt.cell_x        = 12'(idx_nxt[0]);
    out_data_nxt.cell_y        = 12'(idx_nxt[1]);
    out_data_nxt.cell_z        = 12'(idx_nxt[2]);
    out_data_nxt.face_distance = (ent_r.advance && found_r) ? dist_r : mcrt_pkg::DIST_MAX;
    out_data_nxt.crossed_face  = (ent_r.advance && found_r) ? face_r : mcrt_pkg::FACE_NONE;
  end

  // sequencer next state and divider launch
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    side_nxt  = side_r;
    d_nxt     = d_r;
    dist_nxt  = dist_r;
    face_nxt  = face_r;
    found_nxt = found_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    div_req   = '0;
    case (state_r)
      mcrt_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          axis_nxt  = 2'd0;
          found_nxt = 1'b0;
          dist_nxt  = mcrt_pkg::DIST_MAX;
          face_nxt  = mcrt_pkg::FACE_NONE;
          state_nxt = q_entry.advance ? mcrt_pkg::S_MUL : mcrt_pkg::S_LOC;
        end
      end
      mcrt_pkg::S_LOC: begin
        div_req.start    = 1'b1;
        div_req.num      = rel_mag;
        div_req.rem_init = '0;
        div_req.count    = mcrt_pkg::DIV_CNT_W'(mcrt_pkg::DIV_NUM_W);
        div_req.divisor  = pit_a;
        state_nxt        = mcrt_pkg::S_LDIV;
      end
      mcrt_pkg::S_LDIV: begin
        if (div_rsp.done) state_nxt = mcrt_pkg::S_LFIN;
      end
      mcrt_pkg::S_LFIN: begin
        if (axis_r == 2'd2) state_nxt = mcrt_pkg::S_DONE;
        else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = mcrt_pkg::S_LOC;
        end
      end
      mcrt_pkg::S_MUL: state_nxt = mcrt_pkg::S_OFF;
      mcrt_pkg::S_OFF: begin
        side_nxt  = 1'b0;
        state_nxt = mcrt_pkg::S_FACE;
      end
      mcrt_pkg::S_FACE: begin
        if (!can_hit) state_nxt = mcrt_pkg::S_NEXT;
        else if (big) begin
          d_nxt     = mcrt_pkg::DIST_MAX;
          state_nxt = mcrt_pkg::S_CMP;
        end else begin
          // quotient of (mag << 15) / um is below 2^31 here
          div_req.start    = 1'b1;
          div_req.num      = {off_mag[15:0], 17'd0};
          div_req.rem_init = 31'(off_mag[31:16]);
          div_req.count    = mcrt_pkg::DIV_CNT_W'(31);
          div_req.divisor  = 31'(um);
          state_nxt        = mcrt_pkg::S_FDIV;
        end
      end
      mcrt_pkg::S_FDIV: begin
        if (div_rsp.done) begin
          d_nxt     = div_rsp.quot[30:0];
          state_nxt = mcrt_pkg::S_CMP;
        end
      end
      mcrt_pkg::S_CMP: begin
        // strict compare keeps the earlier face on ties
        if (!found_r || d_r < dist_r) begin
          found_nxt = 1'b1;
          dist_nxt  = d_r;
          face_nxt  = {axis_r, side_r} + mcrt_pkg::FACE_NEG_X;
        end
        state_nxt = mcrt_pkg::S_NEXT;
      end
      mcrt_pkg::S_NEXT: begin
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = mcrt_pkg::S_FACE;
        end else if (axis_r == 2'd2) begin
          state_nxt = mcrt_pkg::S_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = mcrt_pkg::S_MUL;
        end
      end
      mcrt_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = mcrt_pkg::S_IDLE;
        end
      end
      default: state_nxt = mcrt_pkg::S_IDLE;
    endcase
  end

  // control state and traversal state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcrt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        idx_r[a]  <= '0;
        flag_r[a] <= mcrt_pkg::FLAG_NONE;
      end
    end else begin
      state_r <= state_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == mcrt_pkg::S_LFIN) begin
        for (int a = 0; a < 3; a++) begin
          if (2'(a) == axis_r) begin
            idx_r[a]  <= INDEX_BITS'(qsat);
            flag_r[a] <= lflag;
          end
        end
      end
      if (load_out) begin
        for (int a = 0; a < 3; a++) begin
          idx_r[a]  <= idx_nxt[a];
          flag_r[a] <= flag_nxt[a];
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    axis_r  <= axis_nxt;
    side_r  <= side_nxt;
    d_r     <= d_nxt;
    dist_r  <= dist_nxt;
    face_r  <= face_nxt;
    found_r <= found_nxt;
    if (q_pop)    ent_r <= q_entry;
    if (state_r == mcrt_pkg::S_MUL) prod_r <= PW'(idx_a) * PW'(signed'({1'b0, pit_a}));
    if (state_r == mcrt_pkg::S_OFF) lo_r <= OW'(org_a) + OW'(prod_r) - OW'(pos_a);
    if (load_out) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/mesh_cell_ray_traversal_core.sv
// top level of the mesh cell ray traversal core
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   mcrt_pkg::in_item_t
//  out_     output     out_valid/out_stall mcrt_pkg::out_item_t
//  cfg_     input      cfg_we              cfg_index, cfg_data
//
// a start transaction runs one division of the 33-bit relative position per axis
// an advance transaction runs a division for each face that it can hit and that is not so far
// that its distance saturates, on the shared divider, which gives one quotient bit per cycle
// a two-entry queue takes new transactions while the back end works or its result waits
// reset (rst_n low, synchronous) clears indices, on-face flags, queue and result valid, and resets the cfg registers
// a stalled result holds in the output register and the back end waits behind it
module mesh_cell_ray_traversal_core #(
  parameter int INDEX_BITS = mcrt_pkg::INDEX_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mcrt_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mcrt_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [mcrt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcrt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic signed [31:0] origin_x_r, origin_y_r, origin_z_r;
  logic [30:0]        pitch_x_r, pitch_y_r, pitch_z_r;
  logic [15:0]        face_tol_r;
  mcrt_pkg::cfg_t     cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      pitch_x_r  <= 31'd65536;
      pitch_y_r  <= 31'd65536;
      pitch_z_r  <= 31'd65536;
      face_tol_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mcrt_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        mcrt_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        mcrt_pkg::CFG_ORIGIN_Z: origin_z_r <= cfg_data;
        mcrt_pkg::CFG_PITCH_X:  pitch_x_r  <= cfg_data[30:0];
        mcrt_pkg::CFG_PITCH_Y:  pitch_y_r  <= cfg_data[30:0];
        mcrt_pkg::CFG_PITCH_Z:  pitch_z_r  <= cfg_data[30:0];
        mcrt_pkg::CFG_FACE_TOL: face_tol_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // zero pitch acts as pitch one
  always_comb begin
    cfg.origin_x = origin_x_r;
    cfg.origin_y = origin_y_r;
    cfg.origin_z = origin_z_r;
    cfg.pitch_x  = (pitch_x_r == '0) ? 31'd1 : pitch_x_r;
    cfg.pitch_y  = (pitch_y_r == '0) ? 31'd1 : pitch_y_r;
    cfg.pitch_z  = (pitch_z_r == '0) ? 31'd1 : pitch_z_r;
    cfg.face_tol = face_tol_r;
  end

  logic                   q_valid, q_pop;
  mcrt_pkg::queue_entry_t q_entry;
  mcrt_pkg::div_req_t     div_req;
  mcrt_pkg::div_rsp_t     div_rsp;

  mcrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  mcrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mcrt_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> design/mcrt_checker.sv
// port-level checks for the mesh cell ray traversal core, bound to the top level
module mcrt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input mcrt_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input mcrt_pkg::out_item_t             out_data,
  input logic                            cfg_we,
  input logic [mcrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [mcrt_pkg::CFG_DATA_W-1:0] cfg_data
);

  // no result right after reset
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // face code within range
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.crossed_face != 3'd7) else $error("bad crossed face code");

  // no crossed face means saturated distance
  a_none_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.crossed_face == mcrt_pkg::FACE_NONE |->
      out_data.face_distance == mcrt_pkg::DIST_MAX)
    else $error("no face but distance not saturated");

endmodule

bind mesh_cell_ray_traversal_core mcrt_checker u_mcrt_checker (.*);

>>> tb/mesh_cell_ray_traversal_core_tb.sv
// self-checking testbench for the mesh cell ray traversal core
module mesh_cell_ray_traversal_core_tb;
  import mcrt_pkg::*;

  localparam longint IDX_HI = 2047;
  localparam longint IDX_LO = -2048;
  localparam longint DMAX = 64'h7fffffff;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mesh_cell_ray_traversal_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mesh setup and traversal state as the predictor sees it
  longint mesh_origin[3];
  longint mesh_pitch[3];
  longint face_tol;
  longint ray_cell[3];
  flag_t ray_flag[3];

  in_item_t pending_rays[$];
  out_item_t expected_cells[$];
  int error_count;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat_cell(longint v);
    if (v > IDX_HI) return IDX_HI;
    if (v < IDX_LO) return IDX_LO;
    return v;
  endfunction

  // distance to a face at signed offset, hit flag in return
  function automatic bit face_hit(longint off, longint dir, output longint fdist);
    longint mag;
    longint um;
    fdist = DMAX;
    if (dir == 0 || off == 0) return 1'b0;
    if ((off > 0) != (dir > 0)) return 1'b0;
    mag = off > 0 ? off : -off;
    um = dir > 0 ? dir : -dir;
    fdist = (mag <<< 15) / um;
    if (fdist > DMAX) fdist = DMAX;
    return 1'b1;
  endfunction

  // traversal prediction for one accepted transaction
  task automatic predict_traversal(input in_item_t it, output out_item_t res);
    longint pos[3];
    longint dir[3];
    longint p;
    longint rel;
    longint q;
    longint rem;
    longint lo;
    longint hi;
    longint d;
    longint best;
    int face;
    int ax;
    pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
    dir[0] = it.dir_x; dir[1] = it.dir_y; dir[2] = it.dir_z;
    best = DMAX;
    face = FACE_NONE;
    if (it.operation == OP_START) begin
      for (int a = 0; a < 3; a++) begin
        p = mesh_pitch[a] == 0 ? 1 : mesh_pitch[a];
        rel = pos[a] - mesh_origin[a];
        q = rel / p;
        rem = rel - q * p;
        if (rem < 0) begin
          q--;
          rem += p;
        end
        ray_flag[a] = FLAG_NONE;
        if (rem < face_tol) begin
          if (dir[a] < 0) begin
            q--;
            ray_flag[a] = FLAG_HIGH;
          end else begin
            ray_flag[a] = FLAG_LOW;
          end
        end else if (p - rem < face_tol) begin
          if (dir[a] < 0) begin
            ray_flag[a] = FLAG_HIGH;
          end else begin
            q++;
            ray_flag[a] = FLAG_LOW;
          end
        end
        ray_cell[a] = sat_cell(q);
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        p = mesh_pitch[a] == 0 ? 1 : mesh_pitch[a];
        lo = mesh_origin[a] + ray_cell[a] * p - pos[a];
        hi = lo + p;
        if (ray_flag[a] != FLAG_LOW && face_hit(lo, dir[a], d)
            && (face == FACE_NONE || d < best)) begin
          best = d;
          face = 2 * a + FACE_NEG_X;
        end
        if (ray_flag[a] != FLAG_HIGH && face_hit(hi, dir[a], d)
            && (face == FACE_NONE || d < best)) begin
          best = d;
          face = 2 * a + FACE_NEG_X + 1;
        end
      end
      for (int a = 0; a < 3; a++) ray_flag[a] = FLAG_NONE;
      if (face != FACE_NONE) begin
        ax = (face - FACE_NEG_X) / 2;
        if (((face - FACE_NEG_X) % 2) == 0) begin
          ray_cell[ax] = sat_cell(ray_cell[ax] - 1);
          ray_flag[ax] = FLAG_HIGH;
        end else begin
          ray_cell[ax] = sat_cell(ray_cell[ax] + 1);
          ray_flag[ax] = FLAG_LOW;
        end
      end else begin
        best = DMAX;
      end
    end
    res.cell_x = ray_cell[0][11:0];
    res.cell_y = ray_cell[1][11:0];
    res.cell_z = ray_cell[2][11:0];
    res.face_distance = best[30:0];
    res.crossed_face = face[2:0];
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // driver: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_traversal(in_data, res);
        expected_cells.push_back(res);
        void'(pending_rays.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_rays.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_rays[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: runs of no stall, light and heavy stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $display("unexpected result transaction at %0t", $time);
        error_count++;
      end else begin
        want = expected_cells.pop_front();
        if (out_data.cell_x !== want.cell_x)
          report_mismatch("cell_x", out_data.cell_x, want.cell_x);
        if (out_data.cell_y !== want.cell_y)
          report_mismatch("cell_y", out_data.cell_y, want.cell_y);
        if (out_data.cell_z !== want.cell_z)
          report_mismatch("cell_z", out_data.cell_z, want.cell_z);
        if (out_data.face_distance !== want.face_distance)
          report_mismatch("face_distance", out_data.face_distance, want.face_distance);
        if (out_data.crossed_face !== want.crossed_face)
          report_mismatch("crossed_face", out_data.crossed_face, want.crossed_face);
      end
    end
  end

  // register write, enable kept high across back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    case (idx)
      CFG_ORIGIN_X: mesh_origin[0] = longint'($signed(val[31:0]));
      CFG_ORIGIN_Y: mesh_origin[1] = longint'($signed(val[31:0]));
      CFG_ORIGIN_Z: mesh_origin[2] = longint'($signed(val[31:0]));
      CFG_PITCH_X: mesh_pitch[0] = val & DMAX;
      CFG_PITCH_Y: mesh_pitch[1] = val & DMAX;
      CFG_PITCH_Z: mesh_pitch[2] = val & DMAX;
      CFG_FACE_TOL: face_tol = val & 64'hffff;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_rays.size() != 0 || in_valid || expected_cells.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return 16'sd0;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return ($urandom_range(0, 1) != 0) ? 16'h0001 : 16'hffff;
      default: return $urandom();
    endcase
  endfunction

  // position near a face or inside a cell a few cells from the origin
  function automatic logic [31:0] pick_pos(int a);
    longint p;
    longint v;
    p = mesh_pitch[a] == 0 ? 1 : mesh_pitch[a];
    v = mesh_origin[a] + ($signed($urandom_range(0, 12)) - 6) * p;
    case ($urandom_range(0, 6))
      0: ;
      1: v += face_tol;
      2: v -= face_tol;
      3: v += face_tol - 1;
      4: v -= face_tol - 1;
      default: v += $urandom_range(0, 32'h7fffffff) % p;
    endcase
    return v[31:0];
  endfunction

  function automatic in_item_t make_ray(logic op, logic [15:0] dx, logic [15:0] dy,
                                        logic [15:0] dz);
    in_item_t it;
    it.operation = op;
    it.pos_x = pick_pos(0);
    it.pos_y = pick_pos(1);
    it.pos_z = pick_pos(2);
    it.dir_x = dx;
    it.dir_y = dy;
    it.dir_z = dz;
    return it;
  endfunction

  // random traffic: mostly a start and a run of advances along one direction
  task automatic queue_random(int count);
    in_item_t it;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
    int run;
    while (count > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        it = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom()};
        pending_rays.push_back(it);
        count--;
      end else begin
        dx = pick_dir();
        dy = pick_dir();
        dz = pick_dir();
        pending_rays.push_back(make_ray(OP_START, dx, dy, dz));
        count--;
        run = $urandom_range(1, 8);
        for (int k = 0; k < run && count > 0; k++) begin
          it = make_ray(OP_ADVANCE, dx, dy, dz);
          if ($urandom_range(0, 2) != 0) begin
            it.pos_x = pending_rays[$].pos_x + $signed($urandom_range(0, 200)) - 100;
            it.pos_y = pending_rays[$].pos_y + $signed($urandom_range(0, 200)) - 100;
            it.pos_z = pending_rays[$].pos_z + $signed($urandom_range(0, 200)) - 100;
          end
          pending_rays.push_back(it);
          count--;
        end
      end
    end
  endtask

  task automatic queue_one(logic op, longint px, longint py, longint pz,
                           logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    in_item_t it;
    it.operation = op;
    it.pos_x = px[31:0];
    it.pos_y = py[31:0];
    it.pos_z = pz[31:0];
    it.dir_x = dx;
    it.dir_y = dy;
    it.dir_z = dz;
    pending_rays.push_back(it);
  endtask

  // stimulus and mesh setup, phase by phase
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    stall_left = 0;
    mesh_origin = '{0, 0, 0};
    mesh_pitch = '{65536, 65536, 65536};
    face_tol = 1;
    ray_cell = '{0, 0, 0};
    ray_flag = '{FLAG_NONE, FLAG_NONE, FLAG_NONE};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset setup, faces, tolerance edges, extremes, no-hit advance
    queue_one(OP_ADVANCE, 32768, 32768, 32768, 16'h4000, 16'hc000, 16'h0000);
    queue_one(OP_START, 0, 0, 0, 16'h7fff, 16'h8000, 16'h0000);
    queue_one(OP_ADVANCE, 0, 0, 0, 16'h7fff, 16'h8000, 16'h0000);
    queue_one(OP_ADVANCE, 100, -5, 0, 16'h7fff, 16'h8000, 16'h0001);
    queue_one(OP_START, 65535, -1, 65536, 16'h0001, 16'hffff, 16'hffff);
    queue_one(OP_ADVANCE, 65535, -1, 65536, 16'h0001, 16'hffff, 16'hffff);
    queue_one(OP_ADVANCE, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    queue_one(OP_START, 32'h7fffffff, -32'sh80000000, 0, 16'h7fff, 16'h8000, 16'h0);
    queue_one(OP_ADVANCE, 32'h7fffffff, -32'sh80000000, 0, 16'h7fff, 16'h8000, 16'h0);
    queue_one(OP_ADVANCE, -32'sh80000000, 32'h7fffffff, 0, 16'h8000, 16'h7fff, 16'h1);
    queue_one(OP_START, 12345, 54321, -99999, 16'h1234, 16'h1234, 16'h1234);
    queue_one(OP_ADVANCE, 12345, 54321, -99999, 16'h1234, 16'h1234, 16'h1234);
    wait_drained();

    write_reg(CFG_ORIGIN_X, 64'h80000000);
    write_reg(CFG_ORIGIN_Y, 64'h7fffffff);
    write_reg(CFG_ORIGIN_Z, 0);
    write_reg(CFG_PITCH_X, 0);
    write_reg(CFG_PITCH_Y, 1);
    write_reg(CFG_PITCH_Z, 64'h7fffffff);
    write_reg(CFG_FACE_TOL, 0);
    end_writes();
    queue_one(OP_START, 0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
    queue_one(OP_ADVANCE, 0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
    queue_one(OP_ADVANCE, 5, -5, 1000, 16'h8000, 16'h7fff, 16'h8000);
    queue_one(OP_START, 32'h7fffffff, -32'sh80000000, -1, 16'h1, 16'h1, 16'h8000);
    queue_one(OP_ADVANCE, 32'h7fffffff, -32'sh80000000, -1, 16'h1, 16'h1, 16'h8000);
    wait_drained();

    // random phases over a range of mesh setups
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ORIGIN_X, (ph == 7) ? 64'h7fffffff : $urandom());
      write_reg(CFG_ORIGIN_Y, (ph == 6) ? 64'h80000000 : $urandom_range(0, 32'h7ffff));
      write_reg(CFG_ORIGIN_Z, $urandom());
      write_reg(CFG_PITCH_X, (ph == 1) ? 0 : $urandom_range(1, 32'h3ffff));
      write_reg(CFG_PITCH_Y, (ph == 2) ? 64'h7fffffff : $urandom_range(1, 32'h7fffffff));
      write_reg(CFG_PITCH_Z, (ph == 3) ? 1 : $urandom_range(16, 32'hfffff));
      write_reg(CFG_FACE_TOL, (ph == 4) ? 65535 : (ph == 5) ? 0 : $urandom_range(0, 65535));
      end_writes();
      queue_random(60);
      // sender holds off until every result is back
      wait_drained();
      queue_random(60);
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_cells.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #36000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
